### rtl/cht_pkg.sv
package cht_pkg;

    localparam int Buckets    = 19;
    localparam int PoolNodes  = 64;
    localparam int ValueBits  = 16;
    localparam int BucketBits = $clog2(Buckets);
    localparam int NodeBits   = $clog2(PoolNodes);
    localparam int LinkBits   = $clog2(PoolNodes + 1);
    localparam int ProbeBits  = 7;

    // Scaled reciprocal of Buckets; the quotient (v * ModRecip) >> ModShift
    // is exact for every ValueBits-wide value at these sizes.
    localparam int ModShift = 20;
    localparam int ModRecip = ((1 << ModShift) + Buckets - 1) / Buckets;

    localparam logic [LinkBits-1:0] LinkNull = LinkBits'(PoolNodes);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_POOL_FULL = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_HEAD,
        S_ALLOC_RD,
        S_ALLOC,
        S_WALK_RD,
        S_WALK_CHK,
        S_TAIL_RD,
        S_TAIL_CHK,
        S_FREE,
        S_REPLY
    } t_state;

    // Mod reducer interface
    typedef struct packed {
        logic                  start;
        logic [ValueBits-1:0]  value;
    } t_mod_req;

    typedef struct packed {
        logic                  done;
        logic [BucketBits-1:0] rem;
    } t_mod_rsp;

    function automatic logic [LinkBits-1:0] norm_link(input logic [LinkBits-1:0] l);
        return (l < LinkBits'(PoolNodes)) ? l : LinkNull;
    endfunction

endpackage

### rtl/chained_hash_table.sv
// Chained hash set of 16-bit values in 19 buckets (value mod 19), with a
// 64-node overflow pool. Pulse start with a command while busy is low;
// busy then stays high until the operation finishes, and the single result
// transaction appears on o_status/o_probe_count for one cycle with o_valid
// high, in the first cycle after busy drops. The receiver cannot stall it:
// sample it that cycle. After acceptance busy covers the mod-19 reducer
// (reciprocal multiply, then remainder), the bucket head, a registered
// node-memory read plus its compare per chain node visited, and the reply
// state. An insert that needs a pool node adds an allocate state, after a
// free-list link read when a freed node is reused, and walks to the chain
// tail if the chain is not empty; a delete that frees a node adds a free
// state, and a head delete with a chain walks to the tail. A find that hits
// the head visits no chain node. Node values and links sit in memories with
// registered reads; never-used nodes are handed out by a fill counter, so no
// clearing pass follows reset.
module chained_hash_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic [1:0]                     i_command,
    input  logic [cht_pkg::ValueBits-1:0]  i_item_value,
    output logic                           busy,
    output logic                           o_valid,
    output logic [1:0]                     o_status,
    output logic [cht_pkg::ProbeBits-1:0]  o_probe_count
);
    import cht_pkg::*;

    localparam int StepBits = $clog2(PoolNodes + 1);

    // Bucket heads
    logic [Buckets-1:0]   r_head_valid;
    logic [ValueBits-1:0] r_head_value [Buckets];
    logic [LinkBits-1:0]  r_head_link  [Buckets];

    // Node pool: values and links in memories, freed nodes on a free list,
    // never-used nodes taken from the fill counter
    logic [ValueBits-1:0] r_node_val  [PoolNodes];
    logic [LinkBits-1:0]  r_node_link [PoolNodes];
    logic [LinkBits-1:0]  r_free_head;
    logic [LinkBits-1:0]  r_fill;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [ValueBits-1:0]  r_val;
    logic [BucketBits-1:0] r_bkt;
    logic [LinkBits-1:0]   r_cur, r_par;     // r_par == LinkNull means head
    logic [LinkBits-1:0]   r_new;
    logic [ProbeBits-1:0]  r_pos;
    logic [StepBits-1:0]   r_steps;
    logic [ValueBits-1:0]  r_rd_val;
    logic [LinkBits-1:0]   r_rd_link;
    logic [1:0]            r_status;
    logic [ProbeBits-1:0]  r_probe;
    logic                  r_valid;

    t_mod_req mod_req;
    t_mod_rsp mod_rsp;

    cht_mod u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mod_req),
        .o_rsp  (mod_rsp)
    );

    logic accept;
    assign accept = start && (r_state == S_IDLE);
    assign mod_req.start = accept;
    assign mod_req.value = i_item_value;

    logic [NodeBits-1:0]  rd_addr;
    logic [LinkBits-1:0]  rd_next;
    logic [LinkBits-1:0]  head_first;
    logic                 head_hit;
    logic                 chain_end;
    logic                 pool_empty;
    assign rd_addr    = (r_state == S_ALLOC_RD) ? r_free_head[NodeBits-1:0]
                                                : r_cur[NodeBits-1:0];
    assign rd_next    = norm_link(r_rd_link);
    assign head_first = norm_link(r_head_link[r_bkt]);
    assign head_hit   = r_head_valid[r_bkt] && (r_head_value[r_bkt] == r_val);
    assign chain_end  = (rd_next == LinkNull) || (r_steps >= StepBits'(PoolNodes - 1));
    assign pool_empty = (r_free_head == LinkNull) && (r_fill == LinkBits'(PoolNodes));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_MOD;
            S_MOD:   if (mod_rsp.done) n_state = S_HEAD;
            S_HEAD: begin
                unique case (r_cmd) inside
                    CMD_INSERT: begin
                        if (!r_head_valid[r_bkt] || pool_empty) begin
                            n_state = S_REPLY;
                        end else if (r_free_head != LinkNull) begin
                            n_state = S_ALLOC_RD;
                        end else begin
                            n_state = S_ALLOC;
                        end
                    end
                    CMD_FIND, CMD_DELETE: begin
                        if (head_hit) begin
                            if (r_cmd == CMD_DELETE && head_first != LinkNull) begin
                                n_state = S_TAIL_RD;
                            end else begin
                                n_state = S_REPLY;
                            end
                        end else if (head_first == LinkNull) begin
                            n_state = S_REPLY;
                        end else begin
                            n_state = S_WALK_RD;
                        end
                    end
                    default: n_state = S_REPLY;
                endcase
            end
            S_ALLOC_RD: n_state = S_ALLOC;
            S_ALLOC:    n_state = (head_first == LinkNull) ? S_REPLY : S_TAIL_RD;
            S_WALK_RD:  n_state = S_WALK_CHK;
            S_WALK_CHK: begin
                if (r_rd_val == r_val) begin
                    n_state = (r_cmd == CMD_DELETE) ? S_FREE : S_REPLY;
                end else if (chain_end) begin
                    n_state = S_REPLY;
                end else begin
                    n_state = S_WALK_RD;
                end
            end
            S_TAIL_RD:  n_state = S_TAIL_CHK;
            S_TAIL_CHK: begin
                if (chain_end) begin
                    n_state = (r_cmd == CMD_DELETE) ? S_FREE : S_REPLY;
                end else begin
                    n_state = S_TAIL_RD;
                end
            end
            S_FREE:     n_state = S_REPLY;
            S_REPLY:    n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Node memory read port: one address a cycle, registered data
    always_ff @(posedge i_clk) begin
        r_rd_val  <= r_node_val[rd_addr];
        r_rd_link <= r_node_link[rd_addr];
    end

    // Datapath and table updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head_valid <= '0;
            r_free_head  <= LinkNull;
            r_fill       <= '0;
            r_valid      <= 1'b0;
            for (int i = 0; i < Buckets; i++) begin
                r_head_link[i] <= LinkNull;
            end
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_REPLY);
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd    <= t_cmd'(i_command);
                        r_val    <= i_item_value;
                        r_status <= ST_DONE;
                        r_probe  <= '0;
                    end
                end
                S_MOD: begin
                    r_bkt   <= mod_rsp.rem;
                    r_pos   <= ProbeBits'(1);
                    r_steps <= '0;
                    r_par   <= LinkNull;
                end
                S_HEAD: begin
                    r_cur <= head_first;
                    unique case (r_cmd) inside
                        CMD_INSERT: begin
                            if (!r_head_valid[r_bkt]) begin
                                r_head_valid[r_bkt] <= 1'b1;
                                r_head_value[r_bkt] <= r_val;
                                r_head_link[r_bkt]  <= LinkNull;
                            end else if (pool_empty) begin
                                r_status <= ST_POOL_FULL;
                            end else if (r_free_head != LinkNull) begin
                                // Reuse a freed node; pop it once its link is read.
                                r_new <= r_free_head;
                            end else begin
                                r_new  <= r_fill;
                                r_fill <= r_fill + 1'b1;
                            end
                        end
                        CMD_FIND, CMD_DELETE: begin
                            if (head_hit) begin
                                if (r_cmd == CMD_FIND) begin
                                    r_probe <= ProbeBits'(1);
                                end else if (head_first == LinkNull) begin
                                    r_head_valid[r_bkt] <= 1'b0;
                                    r_head_link[r_bkt]  <= LinkNull;
                                end
                            end else if (head_first == LinkNull) begin
                                if (r_cmd == CMD_DELETE) r_status <= ST_NOT_FOUND;
                            end
                        end
                        default: ;
                    endcase
                end
                S_ALLOC: begin
                    // Seal the new node; link it at once if the chain is empty.
                    r_node_val[r_new[NodeBits-1:0]]  <= r_val;
                    r_node_link[r_new[NodeBits-1:0]] <= LinkNull;
                    if (r_free_head != LinkNull) begin
                        r_free_head <= rd_next;
                    end
                    if (head_first == LinkNull) begin
                        r_head_link[r_bkt] <= r_new;
                    end
                end
                S_WALK_RD: begin
                    if (r_pos != '1) r_pos <= r_pos + 1'b1;
                end
                S_WALK_CHK: begin
                    if (r_rd_val == r_val) begin
                        if (r_cmd == CMD_FIND) begin
                            r_probe <= r_pos;
                        end else if (r_par == LinkNull) begin
                            // Unlink the matched node; free it next cycle.
                            r_head_link[r_bkt] <= rd_next;
                        end else begin
                            r_node_link[r_par[NodeBits-1:0]] <= rd_next;
                        end
                    end else if (chain_end) begin
                        if (r_cmd == CMD_DELETE) r_status <= ST_NOT_FOUND;
                    end else begin
                        r_par   <= r_cur;
                        r_cur   <= rd_next;
                        r_steps <= r_steps + 1'b1;
                    end
                end
                S_TAIL_CHK: begin
                    if (chain_end) begin
                        if (r_cmd == CMD_DELETE) begin
                            // Pull the tail value into the head and cut the tail off.
                            r_head_value[r_bkt] <= r_rd_val;
                            if (r_par == LinkNull) begin
                                r_head_link[r_bkt] <= LinkNull;
                            end else begin
                                r_node_link[r_par[NodeBits-1:0]] <= LinkNull;
                            end
                        end else begin
                            r_node_link[r_cur[NodeBits-1:0]] <= r_new;
                        end
                    end else begin
                        r_par   <= r_cur;
                        r_cur   <= rd_next;
                        r_steps <= r_steps + 1'b1;
                    end
                end
                S_FREE: begin
                    // Push the dropped node on the free list.
                    r_node_link[r_cur[NodeBits-1:0]] <= r_free_head;
                    r_free_head                      <= r_cur;
                end
                default: ;
            endcase
        end
    end

    // Outputs
    always_comb begin
        busy          = (r_state != S_IDLE);
        o_valid       = r_valid;
        o_status      = r_status;
        o_probe_count = r_probe;
    end

    property p_one_shot;
        @(posedge i_clk) disable iff (!i_rst_n) o_valid |=> !o_valid;
    endproperty
    a_one_shot: assert property (p_one_shot) else $error("result held two cycles");

    property p_valid_from_reply;
        @(posedge i_clk) disable iff (!i_rst_n) o_valid |-> $past(r_state == S_REPLY);
    endproperty
    a_valid_from_reply: assert property (p_valid_from_reply) else $error("stray result");

    property p_probe_only_find;
        @(posedge i_clk) disable iff (!i_rst_n)
            (o_valid && r_cmd != CMD_FIND) |-> o_probe_count == '0;
    endproperty
    a_probe_only_find: assert property (p_probe_only_find) else $error("probe on non-find");

    property p_idle_after_reply;
        @(posedge i_clk) disable iff (!i_rst_n) o_valid |-> !busy;
    endproperty
    a_idle_after_reply: assert property (p_idle_after_reply) else $error("busy at result");

endmodule

### rtl/cht_mod.sv
module cht_mod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cht_pkg::t_mod_req i_req,
    output cht_pkg::t_mod_rsp o_rsp
);
    import cht_pkg::*;

    localparam int RecipBits = $clog2(ModRecip + 1);
    localparam int ProdBits  = ValueBits + RecipBits;
    localparam int QuotBits  = ProdBits - ModShift;

    // Multiply by the reciprocal on start, take the remainder in the following cycle.
    logic [ValueBits-1:0]  r_value, n_value;
    logic [ProdBits-1:0]   r_prod, n_prod;
    logic [BucketBits-1:0] r_rem, n_rem;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [QuotBits-1:0]   quot;

    always_comb begin
        n_value = r_value;
        n_prod  = r_prod;
        n_rem   = r_rem;
        n_busy  = 1'b0;
        n_done  = 1'b0;
        quot    = r_prod[ProdBits-1:ModShift];
        if (i_req.start) begin
            n_value = i_req.value;
            n_prod  = ProdBits'(i_req.value) * ProdBits'(ModRecip);
            n_busy  = 1'b1;
        end else if (r_busy) begin
            n_rem  = BucketBits'(r_value - ValueBits'(quot) * ValueBits'(Buckets));
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_value <= n_value;
        r_prod  <= n_prod;
        r_rem   <= n_rem;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

    property p_rem_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |-> r_rem < BucketBits'(Buckets);
    endproperty
    a_rem_bound: assert property (p_rem_bound) else $error("remainder out of range");

    property p_done_after_busy;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |-> $past(r_busy);
    endproperty
    a_done_after_busy: assert property (p_done_after_busy) else $error("done without work");

    property p_single_request;
        @(posedge i_clk) disable iff (!i_rst_n) r_busy |-> !i_req.start;
    endproperty
    a_single_request: assert property (p_single_request) else $error("request while busy");

endmodule
